### hdl/rsp_pkg.sv
package rsp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  // quotient bits produced by each divider
  localparam int DIV_Q_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_X       = 3'd0,
    CFG_CAMERA_Y       = 3'd1,
    CFG_VIEW_DIR_X     = 3'd2,
    CFG_VIEW_DIR_Y     = 3'd3,
    CFG_CAMERA_PLANE_X = 3'd4,
    CFG_CAMERA_PLANE_Y = 3'd5,
    CFG_VERT_OFFSET    = 3'd6
  } cfg_idx_e;

  localparam logic signed [15:0] RST_VIEW_DIR_X     = 16'sd16384;
  localparam logic signed [15:0] RST_CAMERA_PLANE_Y = 16'sd10813;

  // 0.125 in Q.32
  localparam logic [52:0] CLOSE_LIMIT = 53'd536870912;

  // per-transaction flags carried alongside the dividers
  typedef struct packed {
    logic depth_neg;
    logic center_neg;
    logic special;
    logic too_close;
  } rsp_side_t;

endpackage

### hdl/rsp_div.sv
module rsp_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 44,
  parameter int Q_W   = 24
) (
  input  logic             clk_i,
  input  logic [Q_W:0]     en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o,
  output logic             ovf_o
);

  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int HI_W  = NUM_W - Q_W;
  localparam int OV_W  = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [NUM_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic             ovf_q [Q_W+1];
  logic             ovf_d;

  // quotient does not fit in Q_W bits
  assign ovf_d = OV_W'(num_i[NUM_W-1:Q_W]) >= OV_W'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] den_sh;
    logic [CMP_W-1:0] diff;
    logic             ge;

    assign rem_ext = CMP_W'(rem_q[k-1]);
    assign den_sh  = CMP_W'(den_q[k-1]) << (Q_W - k);
    assign ge      = rem_ext >= den_sh;
    assign diff    = rem_ext - den_sh;

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        quo_q[k] <= quo_q[k-1] | (ge ? (Q_W'(1) << (Q_W - k)) : '0);
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < Q_W) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[k] <= ge ? diff[NUM_W-1:0] : rem_q[k-1];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quo_o = quo_q[Q_W];
  assign ovf_o = ovf_q[Q_W];

endmodule

### hdl/rsp_bounds.sv
module rsp_bounds #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  logic                          clk_i,
  input  logic [1:0]                    en_i,
  input  rsp_pkg::rsp_side_t            side_i,
  input  logic [rsp_pkg::DIV_Q_W-1:0]   quo_dep_i,
  input  logic                          ovf_dep_i,
  input  logic [rsp_pkg::DIV_Q_W-1:0]   quo_cen_i,
  input  logic                          ovf_cen_i,
  input  logic [rsp_pkg::DIV_Q_W-1:0]   quo_siz_i,
  input  logic                          ovf_siz_i,
  input  logic signed [10:0]            vert_offset_i,
  output logic signed [15:0]            screen_center_x_o,
  output logic [15:0]                   sprite_size_o,
  output logic [9:0]                    start_column_o,
  output logic signed [15:0]            end_column_o,
  output logic [9:0]                    start_row_o,
  output logic [9:0]                    end_row_o,
  output logic signed [23:0]            depth_o,
  output logic                          in_front_o,
  output logic                          too_close_o
);
  import rsp_pkg::*;

  localparam logic signed [18:0] ROW_MID = 19'(SCREEN_HEIGHT / 2);
  localparam logic signed [18:0] ROW_MAX = 19'(SCREEN_HEIGHT - 1);
  localparam logic signed [17:0] COL_END = 18'(SCREEN_WIDTH - 1);
  localparam logic signed [17:0] COL_LIM = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] COL_BEG = 18'sd1023;

  // stage 1: sign, saturation and singular case
  logic signed [15:0] center_d, center_q;
  logic [15:0]        size_d, size_q;
  logic signed [23:0] depth_d, depth_q;
  logic               front_d, front_q, close_q;
  logic               dep_big_pos, dep_big_neg, cen_big_pos, cen_big_neg, siz_big;

  assign dep_big_pos = ovf_dep_i || quo_dep_i[23];
  assign dep_big_neg = ovf_dep_i || (quo_dep_i > 24'h800000);
  assign cen_big_pos = ovf_cen_i || (quo_cen_i > DIV_Q_W'(32767));
  assign cen_big_neg = ovf_cen_i || (quo_cen_i > DIV_Q_W'(32768));
  assign siz_big     = ovf_siz_i || (quo_siz_i > DIV_Q_W'(65535));

  always_comb begin
    if (side_i.special) begin
      depth_d  = '0;
      center_d = 16'(SCREEN_WIDTH / 2);
      size_d   = 16'hFFFF;
      front_d  = 1'b0;
    end else begin
      if (side_i.depth_neg) begin
        depth_d = dep_big_neg ? 24'sh800000 : 24'(-quo_dep_i);
      end else begin
        depth_d = dep_big_pos ? 24'sh7FFFFF : 24'(quo_dep_i);
      end
      if (side_i.center_neg) begin
        center_d = cen_big_neg ? 16'sh8000 : 16'(-quo_cen_i);
      end else begin
        center_d = cen_big_pos ? 16'sh7FFF : 16'(quo_cen_i);
      end
      size_d  = siz_big ? 16'hFFFF : quo_siz_i[15:0];
      front_d = !side_i.depth_neg && (ovf_dep_i || quo_dep_i != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      center_q <= center_d;
      size_q   <= size_d;
      depth_q  <= depth_d;
      front_q  <= front_d;
      close_q  <= side_i.too_close;
    end
  end

  // stage 2: draw bounds
  logic [14:0]        half;
  logic signed [18:0] off_ext, half_row, sy, ey, sy_cl, ey_cl;
  logic signed [17:0] cen_ext, half_col, sx, ex, sx_cl, ex_cl;

  assign half     = size_q[15:1];
  assign off_ext  = 19'(vert_offset_i);
  assign half_row = 19'(half);
  assign half_col = 18'(half);
  assign cen_ext  = 18'(center_q);

  always_comb begin
    sy = ROW_MID + off_ext - half_row;
    ey = ROW_MID + off_ext + half_row;
    sx = cen_ext - half_col;
    ex = cen_ext + half_col;
    priority if (sy < 0)       sy_cl = '0;
    else if (sy > ROW_MAX)     sy_cl = ROW_MAX;
    else                       sy_cl = sy;
    priority if (ey < 0)       ey_cl = '0;
    else if (ey > ROW_MAX)     ey_cl = ROW_MAX;
    else                       ey_cl = ey;
    priority if (sx < 0)       sx_cl = '0;
    else if (sx > COL_BEG)     sx_cl = COL_BEG;
    else                       sx_cl = sx;
    ex_cl = (ex >= COL_LIM) ? COL_END : ex;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      screen_center_x_o <= center_q;
      sprite_size_o     <= size_q;
      start_column_o    <= sx_cl[9:0];
      end_column_o      <= ex_cl[15:0];
      start_row_o       <= sy_cl[9:0];
      end_row_o         <= ey_cl[9:0];
      depth_o           <= depth_q;
      in_front_o        <= front_q;
      too_close_o       <= close_q;
    end
  end

endmodule

### hdl/raycast_sprite_projection_top.sv
// Billboard sprite projection for a ray-casting renderer.
// Input channel: in_valid_i / in_stall_o carries one sprite map cell per
// transaction. Output channel: out_valid_o / out_stall_i carries the screen
// center, size, clamped column and row bounds, depth and the in-front and
// too-close flags for that sprite, in input order.
// Camera registers are written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user must write them only while no transaction is in flight; the
// block does not enforce this. Throughput: one transaction per cycle while
// the output is not stalled. The pipeline is 5 front stages (offset,
// products, differences, magnitudes, scaled numerators), three parallel
// restoring dividers of 25 stages each (overflow check plus one quotient
// bit per stage), and 2 output stages.
// Each stage holds its data while the next one is full and stalled, so
// bubbles are squeezed out and input is taken until every stage is full;
// a stalled result holds steady on the output ports.
// Reset clears all valid bits and loads the default camera.
module raycast_sprite_projection_top #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rsp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [9:0]                        sprite_cell_x_i,
  input  logic [9:0]                        sprite_cell_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [15:0]                screen_center_x_o,
  output logic [15:0]                       sprite_size_o,
  output logic [9:0]                        start_column_o,
  output logic signed [15:0]                end_column_o,
  output logic [9:0]                        start_row_o,
  output logic [9:0]                        end_row_o,
  output logic signed [23:0]                depth_o,
  output logic                              in_front_o,
  output logic                              too_close_o
);
  import rsp_pkg::*;

  localparam int NST    = DIV_Q_W + 8;
  localparam int DIV0   = 5;
  localparam int DEN_W  = 44;
  localparam int SIZ_KW = $clog2(3 * SCREEN_WIDTH + 1);
  localparam int NUM_W  = (45 + SIZ_KW > 54) ? 45 + SIZ_KW : 54;
  localparam logic [NUM_W-1:0] HALF_W_K = NUM_W'(SCREEN_WIDTH / 2);
  localparam logic [NUM_W-1:0] SIZE_K   = NUM_W'(3 * SCREEN_WIDTH);

  // configuration
  logic [25:0]        cam_x_q, cam_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic signed [10:0] voff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q   <= '0;
      cam_y_q   <= '0;
      dir_x_q   <= RST_VIEW_DIR_X;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= RST_CAMERA_PLANE_Y;
      voff_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CAMERA_X:       cam_x_q   <= cfg_data_i;
        CFG_CAMERA_Y:       cam_y_q   <= cfg_data_i;
        CFG_VIEW_DIR_X:     dir_x_q   <= cfg_data_i[15:0];
        CFG_VIEW_DIR_Y:     dir_y_q   <= cfg_data_i[15:0];
        CFG_CAMERA_PLANE_X: plane_x_q <= cfg_data_i[15:0];
        CFG_CAMERA_PLANE_Y: plane_y_q <= cfg_data_i[15:0];
        CFG_VERT_OFFSET:    voff_q    <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic [NST-1:0] vld_q, en;

  assign en[NST-1] = !vld_q[NST-1] || !out_stall_i;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NST-1];

  // S1: offset to camera, determinant products
  logic signed [26:0] rx_d, ry_d, rx_q, ry_q;
  logic signed [31:0] p1_q, p2_q;

  assign rx_d = $signed({1'b0, sprite_cell_x_i, 16'h8000}) - $signed({1'b0, cam_x_q});
  assign ry_d = $signed({1'b0, sprite_cell_y_i, 16'h8000}) - $signed({1'b0, cam_y_q});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      p1_q <= plane_x_q * dir_y_q;
      p2_q <= dir_x_q * plane_y_q;
    end
  end

  // S2: camera-space products and squares
  logic signed [42:0] ma_q, mb_q, mc_q, md_q;
  logic signed [53:0] sqx_q, sqy_q;
  logic signed [32:0] det2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ma_q   <= dir_y_q * rx_q;
      mb_q   <= dir_x_q * ry_q;
      mc_q   <= plane_y_q * rx_q;
      md_q   <= plane_x_q * ry_q;
      sqx_q  <= rx_q * rx_q;
      sqy_q  <= ry_q * ry_q;
      det2_q <= 33'(p1_q) - 33'(p2_q);
    end
  end

  // S3: transformed coordinates, distance test
  logic signed [43:0] nx_q, ny_q;
  logic signed [32:0] det3_q;
  logic               close3_q;
  logic [52:0]        dist2;

  assign dist2 = sqx_q[52:0] + sqy_q[52:0];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      nx_q     <= 44'(ma_q) - 44'(mb_q);
      ny_q     <= 44'(md_q) - 44'(mc_q);
      det3_q   <= det2_q;
      close3_q <= dist2 <= CLOSE_LIMIT;
    end
  end

  // S4: magnitudes and signs
  logic signed [44:0] sum;
  logic [44:0]        sum_mag_q;
  logic [43:0]        ny_mag_q;
  logic [32:0]        det_mag_q;
  rsp_side_t          side4_q, side5_q;

  assign sum = 45'(nx_q) + 45'(ny_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sum_mag_q <= sum[44] ? 45'(-sum) : 45'(sum);
      ny_mag_q  <= ny_q[43] ? 44'(-ny_q) : 44'(ny_q);
      det_mag_q <= det3_q[32] ? 33'(-det3_q) : 33'(det3_q);
      side4_q.depth_neg  <= ny_q[43] ^ det3_q[32];
      side4_q.center_neg <= sum[44] ^ ny_q[43];
      side4_q.special    <= (det3_q == '0) || (ny_q == '0);
      side4_q.too_close  <= close3_q;
    end
  end

  // S5: scaled numerators
  logic [NUM_W-1:0] num_dep_q, num_cen_q, num_siz_q;
  logic [DEN_W-1:0] den_dep_q, den_ny_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      num_dep_q <= NUM_W'({ny_mag_q, 10'd0});
      num_cen_q <= NUM_W'(sum_mag_q) * HALF_W_K;
      num_siz_q <= NUM_W'(det_mag_q) * SIZE_K;
      den_dep_q <= DEN_W'(det_mag_q);
      den_ny_q  <= ny_mag_q;
      side5_q   <= side4_q;
    end
  end

  // dividers
  logic [DIV_Q_W:0]   div_en;
  logic [DIV_Q_W-1:0] quo_dep, quo_cen, quo_siz;
  logic               ovf_dep, ovf_cen, ovf_siz;
  rsp_side_t          side_dv_q [DIV_Q_W+1];

  assign div_en = en[DIV0+DIV_Q_W:DIV0];

  rsp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(DIV_Q_W)) u_div_dep (
    .clk_i, .en_i(div_en), .num_i(num_dep_q), .den_i(den_dep_q),
    .quo_o(quo_dep), .ovf_o(ovf_dep)
  );

  rsp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(DIV_Q_W)) u_div_cen (
    .clk_i, .en_i(div_en), .num_i(num_cen_q), .den_i(den_ny_q),
    .quo_o(quo_cen), .ovf_o(ovf_cen)
  );

  rsp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(DIV_Q_W)) u_div_siz (
    .clk_i, .en_i(div_en), .num_i(num_siz_q), .den_i(den_ny_q),
    .quo_o(quo_siz), .ovf_o(ovf_siz)
  );

  always_ff @(posedge clk_i) begin
    if (div_en[0]) side_dv_q[0] <= side5_q;
    for (int k = 1; k <= DIV_Q_W; k++) begin
      if (div_en[k]) side_dv_q[k] <= side_dv_q[k-1];
    end
  end

  rsp_bounds #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_bounds (
    .clk_i,
    .en_i(en[NST-1:NST-2]),
    .side_i(side_dv_q[DIV_Q_W]),
    .quo_dep_i(quo_dep), .ovf_dep_i(ovf_dep),
    .quo_cen_i(quo_cen), .ovf_cen_i(ovf_cen),
    .quo_siz_i(quo_siz), .ovf_siz_i(ovf_siz),
    .vert_offset_i(voff_q),
    .screen_center_x_o, .sprite_size_o, .start_column_o, .end_column_o,
    .start_row_o, .end_row_o, .depth_o, .in_front_o, .too_close_o
  );

endmodule

### hdl/rsp_chk.sv
module rsp_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [15:0]        sprite_size_o,
  input logic signed [23:0] depth_o,
  input logic               in_front_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its depth
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(depth_o))
    else $error("stalled result changed");

  // in-front flag matches a strictly positive depth
  a_front_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (in_front_o == (!depth_o[23] && depth_o != '0)))
    else $error("in_front disagrees with depth");

  // zero depth means the sprite has the saturated size
  a_zero_depth_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && depth_o == '0 |-> sprite_size_o == 16'hFFFF)
    else $error("zero depth without saturated size");

endmodule

bind raycast_sprite_projection_top rsp_chk u_rsp_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .sprite_size_o, .depth_o, .in_front_o
);

### verif/raycast_sprite_projection_top_tb.sv
module raycast_sprite_projection_top_tb;
  import rsp_pkg::*;

  localparam int SCR_W = 1024;
  localparam int SCR_H = 768;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic signed [15:0] center;
    logic [15:0]        size;
    logic [9:0]         start_col;
    logic signed [15:0] end_col;
    logic [9:0]         start_row;
    logic [9:0]         end_row;
    logic signed [23:0] depth;
    logic               in_front;
    logic               too_close;
  } sprite_proj_t;

  class projection_scoreboard;
    longint cam_x, cam_y, dir_x, dir_y, plane_x, plane_y, v_off;
    sprite_proj_t pending[$];
    int errors;
    int checked;

    function new();
      cam_x = 0;
      cam_y = 0;
      dir_x = 16384;
      dir_y = 0;
      plane_x = 0;
      plane_y = 10813;
      v_off = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [25:0] val);
      case (idx)
        CFG_CAMERA_X:       cam_x = longint'(val);
        CFG_CAMERA_Y:       cam_y = longint'(val);
        CFG_VIEW_DIR_X:     dir_x = longint'($signed(val[15:0]));
        CFG_VIEW_DIR_Y:     dir_y = longint'($signed(val[15:0]));
        CFG_CAMERA_PLANE_X: plane_x = longint'($signed(val[15:0]));
        CFG_CAMERA_PLANE_Y: plane_y = longint'($signed(val[15:0]));
        CFG_VERT_OFFSET:    v_off = longint'($signed(val[10:0]));
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note_sprite(logic [9:0] cell_x, logic [9:0] cell_y);
      longint rx, ry, det, nx, ny, dep, ctr, sz, half, sy, ey, sx, ex;
      logic [63:0] d2;
      sprite_proj_t p;
      rx = longint'(cell_x) * 65536 + 32768 - cam_x;
      ry = longint'(cell_y) * 65536 + 32768 - cam_y;
      det = plane_x * dir_y - dir_x * plane_y;
      nx = dir_y * rx - dir_x * ry;
      ny = -plane_y * rx + plane_x * ry;
      if (det == 0 || ny == 0) begin
        dep = 0;
        ctr = SCR_W / 2;
        sz = 65535;
      end else begin
        dep = clip(ny * 1024 / det, -8388608, 8388607);
        ctr = clip(longint'(SCR_W / 2) * (nx + ny) / ny, -32768, 32767);
        sz = 3 * SCR_W * det / ny;
        if (sz < 0) sz = -sz;
        if (sz > 65535) sz = 65535;
      end
      half = sz / 2;
      sy = clip(SCR_H / 2 + v_off - half, 0, SCR_H - 1);
      ey = clip(SCR_H / 2 + v_off + half, 0, SCR_H - 1);
      sx = clip(ctr - half, 0, 1023);
      ex = ctr + half;
      if (ex >= SCR_W) ex = SCR_W - 1;
      ex = clip(ex, -32768, 32767);
      d2 = 64'(rx * rx) + 64'(ry * ry);
      p.center = ctr[15:0];
      p.size = sz[15:0];
      p.start_col = sx[9:0];
      p.end_col = ex[15:0];
      p.start_row = sy[9:0];
      p.end_row = ey[9:0];
      p.depth = dep[23:0];
      p.in_front = (det != 0 && dep > 0);
      p.too_close = (d2 <= 64'd536870912);
      pending.push_back(p);
    endfunction

    function void check_result(sprite_proj_t got);
      sprite_proj_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.center !== e.center) begin
        $error("screen_center_x exp %0d got %0d", e.center, got.center); errors++;
      end
      if (got.size !== e.size) begin
        $error("sprite_size exp %0d got %0d", e.size, got.size); errors++;
      end
      if (got.start_col !== e.start_col) begin
        $error("start_column exp %0d got %0d", e.start_col, got.start_col); errors++;
      end
      if (got.end_col !== e.end_col) begin
        $error("end_column exp %0d got %0d", e.end_col, got.end_col); errors++;
      end
      if (got.start_row !== e.start_row) begin
        $error("start_row exp %0d got %0d", e.start_row, got.start_row); errors++;
      end
      if (got.end_row !== e.end_row) begin
        $error("end_row exp %0d got %0d", e.end_row, got.end_row); errors++;
      end
      if (got.depth !== e.depth) begin
        $error("depth exp %0d got %0d", e.depth, got.depth); errors++;
      end
      if (got.in_front !== e.in_front) begin
        $error("in_front exp %0b got %0b", e.in_front, got.in_front); errors++;
      end
      if (got.too_close !== e.too_close) begin
        $error("too_close exp %0b got %0b", e.too_close, got.too_close); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [9:0] sprite_cell_x_i = '0;
  logic [9:0] sprite_cell_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] screen_center_x_o;
  logic [15:0] sprite_size_o;
  logic [9:0] start_column_o;
  logic signed [15:0] end_column_o;
  logic [9:0] start_row_o;
  logic [9:0] end_row_o;
  logic signed [23:0] depth_o;
  logic in_front_o;
  logic too_close_o;

  projection_scoreboard sb = new();
  bit quiet_mode = 0;
  int idle_cycles = 0;
  int sprites_sent = 0;

  raycast_sprite_projection_top uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result('{screen_center_x_o, sprite_size_o, start_column_o, end_column_o,
                          start_row_o, end_row_o, depth_o, in_front_o, too_close_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      out_stall_i <= quiet_mode ? 1'b0 : ($urandom_range(99) < 8);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [25:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // sends one transaction; valid is held across back-to-back sends
  task automatic send_sprite(logic [9:0] cx, logic [9:0] cy);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 8) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    sprite_cell_x_i <= cx;
    sprite_cell_y_i <= cy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sprite(cx, cy);
    sprites_sent++;
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_camera(logic [25:0] px, logic [25:0] py, logic [15:0] dx,
                             logic [15:0] dy, logic [15:0] plx, logic [15:0] ply,
                             logic [10:0] off);
    wait_drained();
    write_reg(CFG_CAMERA_X, px);
    write_reg(CFG_CAMERA_Y, py);
    write_reg(CFG_VIEW_DIR_X, 26'(dx));
    write_reg(CFG_VIEW_DIR_Y, 26'(dy));
    write_reg(CFG_CAMERA_PLANE_X, 26'(plx));
    write_reg(CFG_CAMERA_PLANE_Y, 26'(ply));
    write_reg(CFG_VERT_OFFSET, 26'(off));
  endtask

  function automatic logic [9:0] near_cell(logic [25:0] cam);
    int c;
    c = int'(cam >> 16) + $urandom_range(8) - 4;
    if (c < 0) c = 0;
    if (c > 999) c = 999;
    return c[9:0];
  endfunction

  initial begin
    logic [25:0] px, py;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default camera: extremes, camera cell
    send_sprite(10'd0, 10'd0);
    send_sprite(10'd999, 10'd999);
    send_sprite(10'd0, 10'd999);
    send_sprite(10'd999, 10'd0);
    send_sprite(10'd1023, 10'd1023);
    send_sprite(10'd5, 10'd0);
    end_burst();
    // singular camera
    load_camera(26'd0, 26'd0, 16'd16384, 16'd0, 16'd16384, 16'd0, 11'd0);
    send_sprite(10'd3, 10'd7);
    send_sprite(10'd0, 10'd0);
    end_burst();
    // zero depth: ny == 0 with sprite on camera line, far sides, off extremes
    load_camera(26'd32768, 26'd32768, 16'd16384, 16'd0, 16'd0, 16'd10813, 11'h2FF);
    send_sprite(10'd0, 10'd0);
    send_sprite(10'd0, 10'd900);
    send_sprite(10'd1, 10'd600);
    send_sprite(10'd999, 10'd500);
    end_burst();
    load_camera(26'h3FFFFFF, 26'h3FFFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 11'h500);
    send_sprite(10'd1023, 10'd1023);
    send_sprite(10'd0, 10'd0);
    send_sprite(10'd999, 10'd998);
    send_sprite(10'd512, 10'd100);
    end_burst();
    load_camera(26'd100 << 16, 26'd100 << 16, 16'd0, 16'hC000, 16'd10813, 16'd0, 11'd0);
    send_sprite(10'd100, 10'd101);
    send_sprite(10'd130, 10'd40);
    send_sprite(10'd70, 10'd10);
    send_sprite(10'd100, 10'd800);
    end_burst();

    // sender holds off until everything has drained
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      px = 26'($urandom_range(26'h3FFFFFF));
      py = 26'($urandom_range(26'h3FFFFFF));
      if (ph % 3 != 0) begin
        px = 26'($urandom_range(1000 << 16));
        py = 26'($urandom_range(1000 << 16));
      end
      load_camera(px, py, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  11'($signed($urandom_range(1535)) - 768));
      quiet_mode = (ph == 5);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(1))
          send_sprite(near_cell(px), near_cell(py));
        else
          send_sprite(10'($urandom), 10'($urandom));
      end
      end_burst();
    end
    quiet_mode = 0;

    wait_drained();
    $display("Projected %0d sprites over 17 camera setups, including singular,",
             sprites_sent);
    $display("zero-depth, close-range and saturating cases; %0d results checked.",
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

### sim.f
hdl/rsp_pkg.sv
hdl/rsp_div.sv
hdl/rsp_bounds.sv
hdl/raycast_sprite_projection_top.sv
hdl/rsp_chk.sv
verif/raycast_sprite_projection_top_tb.sv
